// ----- src/tsd_pkg.sv -----
// Shared types, token class codes and character constants for the token scanner.
// Used by tsd_front, tsd_queue, tsd_back and token_scanner_dfa_core. No dependencies.
`default_nettype none

package tsd_pkg;

	// Scanner states; every 3-bit code is a real state.
	typedef enum logic [2:0] {
		ST_START   = 3'd0,
		ST_IDENT   = 3'd1,
		ST_INT     = 3'd2,
		ST_REAL    = 3'd3,
		ST_COLON   = 3'd4,
		ST_LT      = 3'd5,
		ST_GT      = 3'd6,
		ST_COMMENT = 3'd7
	} scan_state_t;

	// Token class codes as they appear on the result port.
	localparam logic [4:0] CLS_END      = 5'd0;
	localparam logic [4:0] CLS_IDENT    = 5'd1;
	localparam logic [4:0] CLS_INT      = 5'd2;
	localparam logic [4:0] CLS_REAL     = 5'd3;
	localparam logic [4:0] CLS_ASSIGN   = 5'd4;
	localparam logic [4:0] CLS_COLON    = 5'd5;
	localparam logic [4:0] CLS_LT       = 5'd6;
	localparam logic [4:0] CLS_LE       = 5'd7;
	localparam logic [4:0] CLS_NE       = 5'd8;
	localparam logic [4:0] CLS_GT       = 5'd9;
	localparam logic [4:0] CLS_GE       = 5'd10;
	localparam logic [4:0] CLS_EQ       = 5'd11;
	localparam logic [4:0] CLS_PLUS     = 5'd12;
	localparam logic [4:0] CLS_MINUS    = 5'd13;
	localparam logic [4:0] CLS_STAR     = 5'd14;
	localparam logic [4:0] CLS_SLASH    = 5'd15;
	localparam logic [4:0] CLS_SEMI     = 5'd16;
	localparam logic [4:0] CLS_COMMA    = 5'd17;
	localparam logic [4:0] CLS_DOT      = 5'd18;
	localparam logic [4:0] CLS_LPAREN   = 5'd19;
	localparam logic [4:0] CLS_RPAREN   = 5'd20;
	localparam logic [4:0] CLS_BAD      = 5'd21;
	localparam logic [4:0] CLS_OPEN_CMT = 5'd22;

	// Characters the scanner looks at.
	localparam logic [7:0] CH_LBRACE = 8'h7B;
	localparam logic [7:0] CH_RBRACE = 8'h7D;
	localparam logic [7:0] CH_COLON  = 8'h3A;
	localparam logic [7:0] CH_LT     = 8'h3C;
	localparam logic [7:0] CH_GT     = 8'h3E;
	localparam logic [7:0] CH_EQ     = 8'h3D;
	localparam logic [7:0] CH_DOT    = 8'h2E;
	localparam logic [7:0] CH_LF     = 8'h0A;
	localparam logic [7:0] CH_TAB    = 8'h09;
	localparam logic [7:0] CH_CR     = 8'h0D;
	localparam logic [7:0] CH_SPACE  = 8'h20;
	localparam logic [7:0] CH_PLUS   = 8'h2B;
	localparam logic [7:0] CH_MINUS  = 8'h2D;
	localparam logic [7:0] CH_STAR   = 8'h2A;
	localparam logic [7:0] CH_SLASH  = 8'h2F;
	localparam logic [7:0] CH_SEMI   = 8'h3B;
	localparam logic [7:0] CH_COMMA  = 8'h2C;
	localparam logic [7:0] CH_LPAREN = 8'h28;
	localparam logic [7:0] CH_RPAREN = 8'h29;

	// Position counter limits.
	localparam logic [19:0] LINE_MAX = 20'hFFFFF;
	localparam logic [15:0] COL_MAX  = 16'hFFFF;

	// Depth of the run queue between the front and the back.
	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

	// One token as it leaves the block.
	typedef struct packed {
		logic [4:0]  cls;
		logic [19:0] line;
		logic [15:0] col;
		logic [6:0]  len;
		logic [7:0]  lead;
	} token_t;

	// All tokens caused by one input beat: one or two.
	typedef struct packed {
		logic   two;
		token_t tok0;
		token_t tok1;
	} run_t;

	// Queue status seen by the front and the back.
	typedef struct packed {
		logic full;
		logic avail;
	} q_stat_t;

	function automatic logic is_letter(input logic [7:0] b);
		return (b >= 8'h41 && b <= 8'h5A) || (b >= 8'h61 && b <= 8'h7A);
	endfunction

	function automatic logic is_digit(input logic [7:0] b);
		return b >= 8'h30 && b <= 8'h39;
	endfunction

	function automatic logic is_space(input logic [7:0] b);
		return b == CH_SPACE || (b >= CH_TAB && b <= CH_CR);
	endfunction

	// Class of a character that forms a token on its own.
	function automatic logic [4:0] single_class(input logic [7:0] b);
		logic [4:0] c;
		case (b)
			CH_EQ:     c = CLS_EQ;
			CH_PLUS:   c = CLS_PLUS;
			CH_MINUS:  c = CLS_MINUS;
			CH_STAR:   c = CLS_STAR;
			CH_SLASH:  c = CLS_SLASH;
			CH_SEMI:   c = CLS_SEMI;
			CH_COMMA:  c = CLS_COMMA;
			CH_DOT:    c = CLS_DOT;
			CH_LPAREN: c = CLS_LPAREN;
			CH_RPAREN: c = CLS_RPAREN;
			default:   c = CLS_BAD;
		endcase
		return c;
	endfunction

endpackage

`default_nettype wire

// ----- src/token_scanner_dfa_core.sv -----
// Top level of the byte-serial token scanner: front, run queue and back end.
// Depends on tsd_pkg, tsd_front, tsd_queue and tsd_back.
//
//   channel  | direction | handshake    | beat
//   input    | in        | push / full  | in_byte, end_mark
//   result   | out       | empty / pop  | token_class .. lead_byte, last_of_run
//
// The front takes one byte each cycle while the run queue has room; its scan
// state, position and token counters update in that same cycle. A run of one token
// reaches the result ports through the queue store and the back end's run register;
// a run of two tokens occupies the back end for two result beats. full rises when
// the four-entry run queue is full; while pop is held, the back end drains one token
// per cycle, so sustained input is one byte per cycle except where bytes end two tokens.
// arst_n clears the scan state to start, line and column to 1, and empties the queue.
`default_nettype none

module token_scanner_dfa_core #(
	parameter int MAX_LEXEME = 64
) (
	input  wire         clk,
	input  wire         arst_n,
	input  wire         push,
	output logic        full,
	input  wire  [7:0]  in_byte,
	input  wire         end_mark,
	output logic        empty,
	input  wire         pop,
	output logic [4:0]  token_class,
	output logic [19:0] start_line,
	output logic [15:0] start_column,
	output logic [6:0]  token_length,
	output logic [7:0]  lead_byte,
	output logic        last_of_run
);

	tsd_pkg::run_t    wr_rec, rd_rec;
	tsd_pkg::q_stat_t q_stat;
	tsd_pkg::token_t  tok;
	logic             take, run_push, q_pop;

	assign full = q_stat.full;
	assign take = push && !q_stat.full;

	tsd_front #(
		.MAX_LEXEME(MAX_LEXEME)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.take     (take),
		.in_byte  (in_byte),
		.end_mark (end_mark),
		.run_push (run_push),
		.run_rec  (wr_rec)
	);

	tsd_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (run_push),
		.wr_rec (wr_rec),
		.pop    (q_pop),
		.rd_rec (rd_rec),
		.stat   (q_stat)
	);

	tsd_back u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.q_avail (q_stat.avail),
		.q_rec   (rd_rec),
		.q_pop   (q_pop),
		.pop     (pop),
		.empty   (empty),
		.tok     (tok),
		.last    (last_of_run)
	);

	// Result fields.
	assign token_class  = tok.cls;
	assign start_line   = tok.line;
	assign start_column = tok.col;
	assign token_length = tok.len;
	assign lead_byte    = tok.lead;

	// The front never pushes into a full queue.
	a_no_push_full: assert property (@(posedge clk) disable iff (!arst_n)
		run_push |-> !q_stat.full)
		else $error("run pushed while queue full");

	// The back end never pops an empty queue.
	a_no_pop_empty: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |-> q_stat.avail)
		else $error("run popped from empty queue");

	// End and unclosed-comment tokens never lead a two-token run.
	a_end_leads_not: assert property (@(posedge clk) disable iff (!arst_n)
		(run_push && wr_rec.two) |->
		(wr_rec.tok0.cls != tsd_pkg::CLS_END && wr_rec.tok0.cls != tsd_pkg::CLS_OPEN_CMT))
		else $error("end token placed before another token");

	// A token that was shown but not taken stays on the ports.
	a_hold_token: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && !pop) |=> (!empty && $stable(token_class) && $stable(last_of_run)))
		else $error("waiting token changed");

endmodule

`default_nettype wire

// ----- src/tsd_front.sv -----
// Scanner front: holds the scan state and position counters, classifies each
// input beat and forms the run of tokens it causes. Depends on tsd_pkg.
`default_nettype none

module tsd_front #(
	parameter int MAX_LEXEME = 64
) (
	input  wire              clk,
	input  wire              arst_n,
	input  wire              take,
	input  wire  [7:0]       in_byte,
	input  wire              end_mark,
	output logic             run_push,
	output tsd_pkg::run_t    run_rec
);

	localparam int LW = $clog2(MAX_LEXEME + 1);
	localparam logic [LW-1:0] LEN_MAX = LW'(MAX_LEXEME);

	tsd_pkg::scan_state_t state_q, state_d;
	logic [19:0]   line_q, line_d, tline_q, tline_d;
	logic [15:0]   col_q, col_d, tcol_q, tcol_d;
	logic [LW-1:0] len_q, len_d, len_inc;
	logic [7:0]    first_q, first_d;

	logic        letter, digit, space, pend_cont, pend_close, pend_emit, start_pass;
	logic        cmt_emit, start_emit;
	logic [19:0] adv_line;
	logic [15:0] adv_col;
	logic [4:0]  pend_cls, start_cls;
	tsd_pkg::token_t pend_tok, cmt_tok, start_tok;

	// Character classes, saturating counters and the decision on a pending token.
	always_comb begin
		letter  = tsd_pkg::is_letter(in_byte);
		digit   = tsd_pkg::is_digit(in_byte);
		space   = tsd_pkg::is_space(in_byte);
		len_inc = (len_q < LEN_MAX) ? len_q + LW'(1) : len_q;
		if (in_byte == tsd_pkg::CH_LF) begin
			adv_line = (line_q < tsd_pkg::LINE_MAX) ? line_q + 20'd1 : line_q;
			adv_col  = 16'd1;
		end else begin
			adv_line = line_q;
			adv_col  = (col_q < tsd_pkg::COL_MAX) ? col_q + 16'd1 : col_q;
		end
		pend_cont  = 1'b0;
		pend_close = 1'b0;
		pend_emit  = 1'b0;
		start_pass = 1'b0;
		cmt_emit   = 1'b0;
		case (state_q)
			tsd_pkg::ST_IDENT: begin
				pend_cont = !end_mark && (letter || digit);
				pend_emit = !pend_cont;
			end
			tsd_pkg::ST_INT: begin
				pend_cont = !end_mark && (digit || in_byte == tsd_pkg::CH_DOT);
				pend_emit = !pend_cont;
			end
			tsd_pkg::ST_REAL: begin
				pend_cont = !end_mark && digit;
				pend_emit = !pend_cont;
			end
			tsd_pkg::ST_COLON, tsd_pkg::ST_GT: begin
				pend_close = !end_mark && in_byte == tsd_pkg::CH_EQ;
				pend_emit  = !pend_close;
			end
			tsd_pkg::ST_LT: begin
				pend_close = !end_mark &&
					(in_byte == tsd_pkg::CH_EQ || in_byte == tsd_pkg::CH_GT);
				pend_emit  = !pend_close;
			end
			tsd_pkg::ST_COMMENT: begin
				cmt_emit = end_mark;
			end
			default: begin
				start_pass = 1'b1;
			end
		endcase
		// A byte that ends a pending token is scanned again from the start.
		if (pend_emit) begin
			start_pass = 1'b1;
		end
		start_emit = start_pass && (end_mark || (!space && !letter && !digit &&
			in_byte != tsd_pkg::CH_LBRACE && in_byte != tsd_pkg::CH_COLON &&
			in_byte != tsd_pkg::CH_LT && in_byte != tsd_pkg::CH_GT));
	end

	// Next state of the scanner and its counters.
	always_comb begin
		state_d = state_q;
		line_d  = line_q;
		col_d   = col_q;
		tline_d = tline_q;
		tcol_d  = tcol_q;
		len_d   = len_q;
		first_d = first_q;
		if (pend_cont || pend_close) begin
			len_d  = len_inc;
			line_d = adv_line;
			col_d  = adv_col;
			if (pend_close) begin
				state_d = tsd_pkg::ST_START;
			end else if (state_q == tsd_pkg::ST_INT && in_byte == tsd_pkg::CH_DOT) begin
				state_d = tsd_pkg::ST_REAL;
			end
		end
		if (state_q == tsd_pkg::ST_COMMENT) begin
			if (end_mark) begin
				state_d = tsd_pkg::ST_START;
			end else begin
				if (in_byte == tsd_pkg::CH_RBRACE) begin
					state_d = tsd_pkg::ST_START;
				end
				line_d = adv_line;
				col_d  = adv_col;
			end
		end
		if (start_pass) begin
			state_d = tsd_pkg::ST_START;
			if (!end_mark) begin
				line_d = adv_line;
				col_d  = adv_col;
				if (!space) begin
					tline_d = line_q;
					tcol_d  = col_q;
					first_d = in_byte;
					len_d   = LW'(1);
					if (letter) begin
						state_d = tsd_pkg::ST_IDENT;
					end else if (digit) begin
						state_d = tsd_pkg::ST_INT;
					end else if (in_byte == tsd_pkg::CH_LBRACE) begin
						state_d = tsd_pkg::ST_COMMENT;
					end else if (in_byte == tsd_pkg::CH_COLON) begin
						state_d = tsd_pkg::ST_COLON;
					end else if (in_byte == tsd_pkg::CH_LT) begin
						state_d = tsd_pkg::ST_LT;
					end else if (in_byte == tsd_pkg::CH_GT) begin
						state_d = tsd_pkg::ST_GT;
					end
				end
			end
		end
	end

	// Tokens formed by this beat and their packing into one run.
	always_comb begin
		case (state_q)
			tsd_pkg::ST_IDENT: pend_cls = tsd_pkg::CLS_IDENT;
			tsd_pkg::ST_INT:   pend_cls = tsd_pkg::CLS_INT;
			tsd_pkg::ST_REAL:  pend_cls = tsd_pkg::CLS_REAL;
			tsd_pkg::ST_COLON: pend_cls = pend_close ? tsd_pkg::CLS_ASSIGN : tsd_pkg::CLS_COLON;
			tsd_pkg::ST_GT:    pend_cls = pend_close ? tsd_pkg::CLS_GE : tsd_pkg::CLS_GT;
			tsd_pkg::ST_LT: begin
				if (!pend_close) begin
					pend_cls = tsd_pkg::CLS_LT;
				end else if (in_byte == tsd_pkg::CH_EQ) begin
					pend_cls = tsd_pkg::CLS_LE;
				end else begin
					pend_cls = tsd_pkg::CLS_NE;
				end
			end
			default: pend_cls = tsd_pkg::CLS_BAD;
		endcase
		start_cls = end_mark ? tsd_pkg::CLS_END : tsd_pkg::single_class(in_byte);

		pend_tok.cls  = pend_cls;
		pend_tok.line = tline_q;
		pend_tok.col  = tcol_q;
		pend_tok.len  = 7'(pend_close ? len_inc : len_q);
		pend_tok.lead = first_q;

		cmt_tok.cls  = tsd_pkg::CLS_OPEN_CMT;
		cmt_tok.line = line_q;
		cmt_tok.col  = col_q;
		cmt_tok.len  = 7'd0;
		cmt_tok.lead = 8'd0;

		start_tok.cls  = start_cls;
		start_tok.line = line_q;
		start_tok.col  = col_q;
		start_tok.len  = end_mark ? 7'd0 : 7'd1;
		start_tok.lead = end_mark ? 8'd0 : in_byte;

		if (pend_close || pend_emit) begin
			run_rec.tok0 = pend_tok;
		end else if (cmt_emit) begin
			run_rec.tok0 = cmt_tok;
		end else begin
			run_rec.tok0 = start_tok;
		end
		run_rec.tok1 = start_tok;
		run_rec.two  = pend_emit && start_emit;
		run_push     = take && (pend_close || pend_emit || cmt_emit || start_emit);
	end

	// Scanner state; moves only on an accepted beat.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= tsd_pkg::ST_START;
			line_q  <= 20'd1;
			col_q   <= 16'd1;
			tline_q <= 20'd1;
			tcol_q  <= 16'd1;
			len_q   <= '0;
			first_q <= 8'd0;
		end else if (take) begin
			state_q <= state_d;
			line_q  <= line_d;
			col_q   <= col_d;
			tline_q <= tline_d;
			tcol_q  <= tcol_d;
			len_q   <= len_d;
			first_q <= first_d;
		end
	end

endmodule

`default_nettype wire

// ----- src/tsd_queue.sv -----
// Short run queue between the scanner front and the token back end.
// Depends on tsd_pkg for the run record and the queue depth.
`default_nettype none

module tsd_queue (
	input  wire                clk,
	input  wire                arst_n,
	input  wire                push,
	input  tsd_pkg::run_t      wr_rec,
	input  wire                pop,
	output tsd_pkg::run_t      rd_rec,
	output tsd_pkg::q_stat_t   stat
);

	tsd_pkg::run_t store_q [tsd_pkg::QUEUE_DEPTH];
	logic [tsd_pkg::QPTR_W-1:0] wptr_q, rptr_q;
	logic [tsd_pkg::QPTR_W:0]   count_q;
	logic                       do_push, do_pop;

	// Status and guarded handshakes.
	always_comb begin
		stat.full  = count_q == (tsd_pkg::QPTR_W + 1)'(tsd_pkg::QUEUE_DEPTH);
		stat.avail = count_q != '0;
		do_push    = push && !stat.full;
		do_pop     = pop && stat.avail;
		rd_rec     = store_q[rptr_q];
	end

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q  <= '0;
			rptr_q  <= '0;
			count_q <= '0;
		end else begin
			if (do_push) begin
				wptr_q <= wptr_q + tsd_pkg::QPTR_W'(1);
			end
			if (do_pop) begin
				rptr_q <= rptr_q + tsd_pkg::QPTR_W'(1);
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + (tsd_pkg::QPTR_W + 1)'(1);
			end else if (do_pop && !do_push) begin
				count_q <= count_q - (tsd_pkg::QPTR_W + 1)'(1);
			end
		end
	end

	// Entry storage.
	always_ff @(posedge clk) begin
		if (do_push) begin
			store_q[wptr_q] <= wr_rec;
		end
	end

endmodule

`default_nettype wire

// ----- src/tsd_back.sv -----
// Token back end: takes runs from the queue and hands out one token per beat
// from an output register. Depends on tsd_pkg.
`default_nettype none

module tsd_back (
	input  wire                clk,
	input  wire                arst_n,
	input  wire                q_avail,
	input  tsd_pkg::run_t      q_rec,
	output logic               q_pop,
	input  wire                pop,
	output logic               empty,
	output tsd_pkg::token_t    tok,
	output logic               last
);

	tsd_pkg::run_t rec_q;
	logic          vld_q, idx_q;
	logic          finish, load;

	// A run is done when its last token is taken.
	always_comb begin
		finish = vld_q && pop && (idx_q || !rec_q.two);
		load   = !vld_q || finish;
		q_pop  = load && q_avail;
		empty  = !vld_q;
		tok    = idx_q ? rec_q.tok1 : rec_q.tok0;
		last   = idx_q || !rec_q.two;
	end

	// Output valid and the token index within the run.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
			idx_q <= 1'b0;
		end else if (load) begin
			vld_q <= q_avail;
			idx_q <= 1'b0;
		end else if (vld_q && pop) begin
			idx_q <= 1'b1;
		end
	end

	// Run register.
	always_ff @(posedge clk) begin
		if (q_pop) begin
			rec_q <= q_rec;
		end
	end

endmodule

`default_nettype wire
